// ===== rtl/ccoc_pkg.sv =====
// Shared types and constants for the cyclic cluster orbit checker.
package ccoc_pkg;

    localparam int CfgWidth      = 15;
    localparam int MaxLengthDef  = 16384;
    localparam int MultWidth     = 14;

    // Configuration register indexes
    localparam logic [1:0] RegPolyLength   = 2'd0;
    localparam logic [1:0] RegTargetWeight = 2'd1;
    localparam logic [1:0] RegWindowLength = 2'd2;
    localparam logic [1:0] RegEpsilonMode  = 2'd3;

    // Configuration handed to the search engine
    typedef struct packed {
        logic [CfgWidth-1:0] r;
        logic [CfgWidth-1:0] m;
        logic [CfgWidth-1:0] target;
    } srch_cfg_t;

    // Search engine status
    typedef struct packed {
        logic                 done;
        logic                 found;
        logic [MultWidth-1:0] mult;
    } srch_stat_t;

endpackage

// ===== rtl/ccoc_gcd.sv =====
// Iterative subtract-and-swap gcd unit, one step per cycle.
module ccoc_gcd import ccoc_pkg::*; #(
    parameter int W = CfgWidth
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         start,
    input  logic [W-1:0] a_in,
    input  logic [W-1:0] b_in,
    output logic         done,
    output logic         coprime
);
    logic [W-1:0] a_reg, a_next, b_reg, b_next;
    logic         busy_reg, busy_next;

    // One compare-subtract step per cycle until one operand reaches zero
    always_comb begin
        a_next    = a_reg;
        b_next    = b_reg;
        busy_next = busy_reg;
        if (start) begin
            a_next    = a_in;
            b_next    = b_in;
            busy_next = 1'b1;
        end else if (busy_reg) begin
            if (b_reg == '0) begin
                busy_next = 1'b0;
            end else if (a_reg >= b_reg) begin
                a_next = a_reg - b_reg;
            end else begin
                a_next = b_reg;
                b_next = a_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
        end
        a_reg <= a_next;
        b_reg <= b_next;
    end

    assign done    = busy_reg && (b_reg == '0) && !start;
    assign coprime = (a_reg == W'(1));
endmodule

// ===== rtl/ccoc_search.sv =====
// Orbit search sequencer: multiplier scan, permutation and sliding window.
module ccoc_search import ccoc_pkg::*; #(
    parameter int MaxLength = MaxLengthDef,
    parameter int AW        = $clog2(MaxLength)
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              start,
    input  srch_cfg_t         cfg,
    output logic [AW-1:0]     prd_addr,
    input  logic              pbit,
    output srch_stat_t        stat
);
    typedef enum logic [7:0] {
        S_IDLE = 8'b00000001,
        S_GCD  = 8'b00000010,
        S_PERM = 8'b00000100,
        S_WIN  = 8'b00001000,
        S_SLO  = 8'b00010000,
        S_SLI  = 8'b00100000,
        S_NEXT = 8'b01000000,
        S_DONE = 8'b10000000
    } st_t;

    localparam int CW = AW + 1;

    st_t           st_reg, st_next;
    logic [CW-1:0] i_reg, i_next;     // multiplier
    logic [CW-1:0] p_reg, p_next;     // source index / window step
    logic [CW-1:0] pos_reg, pos_next; // permuted position
    logic [CW-1:0] cnt_reg, cnt_next;
    logic          found_reg, found_next;
    logic          wr_en;
    logic [AW-1:0] wr_addr, rd_addr;
    logic          perm_mem [MaxLength];
    logic          perm_q;
    logic          pend_reg, pend_next;  // read data valid next cycle
    logic          sub_reg, sub_next;    // pending op: 1 subtract, 0 add
    logic          gcd_start, gcd_done, gcd_cop;
    logic [CW:0]   pos_sum, in_sum;
    logic [CW-1:0] eff_cnt;

    ccoc_gcd #(.W(CW)) u_gcd (
        .aclk(aclk), .aresetn(aresetn), .start(gcd_start),
        .a_in(i_reg), .b_in(CW'(cfg.r)), .done(gcd_done), .coprime(gcd_cop)
    );

    // Permuted store: one write, one registered read per cycle
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            perm_mem[wr_addr] <= pbit;
        end
        perm_q <= perm_mem[rd_addr];
    end

    assign pos_sum = {1'b0, pos_reg} + {1'b0, i_reg};
    assign in_sum  = {1'b0, p_reg} + {1'b0, cfg.m} - (CW+1)'(1);
    // polynomial read is addressed with p_next so the registered pbit matches p_reg
    assign prd_addr = p_next[AW-1:0];
    // count with the pending read folded in
    assign eff_cnt = !pend_reg ? cnt_reg :
                     (sub_reg ? cnt_reg - CW'(perm_q) : cnt_reg + CW'(perm_q));

    always_comb begin
        st_next    = st_reg;
        i_next     = i_reg;
        p_next     = p_reg;
        pos_next   = pos_reg;
        cnt_next   = cnt_reg;
        found_next = found_reg;
        pend_next  = 1'b0;
        sub_next   = sub_reg;
        gcd_start  = 1'b0;
        wr_en      = 1'b0;
        wr_addr    = pos_reg[AW-1:0];
        rd_addr    = p_reg[AW-1:0];
        case (st_reg)
            S_IDLE: begin
                if (start) begin
                    i_next     = CW'(1);
                    found_next = 1'b0;
                    st_next    = S_NEXT;
                end
            end
            // check multiplier range, then its gcd with r
            S_NEXT: begin
                if (i_reg >= cfg.r) begin
                    st_next = S_DONE;
                end else begin
                    gcd_start = 1'b1;
                    st_next   = S_GCD;
                end
            end
            S_GCD: begin
                if (gcd_done) begin
                    if (gcd_cop) begin
                        p_next   = '0;
                        pos_next = '0;
                        st_next  = S_PERM;
                    end else begin
                        i_next  = i_reg + CW'(1);
                        st_next = S_NEXT;
                    end
                end
            end
            // poly bit p comes in as pbit, addressed the cycle before
            S_PERM: begin
                wr_en    = 1'b1;
                p_next   = p_reg + CW'(1);
                pos_next = (pos_sum >= {1'b0, cfg.r}) ? CW'(pos_sum - {1'b0, cfg.r})
                                                       : CW'(pos_sum);
                if (p_reg + CW'(1) >= cfg.r) begin
                    p_next   = '0;
                    cnt_next = '0;
                    st_next  = S_WIN;
                end
            end
            // first window: sum bits 0..m-1, reads pipelined
            S_WIN: begin
                cnt_next  = eff_cnt;
                if (p_reg < cfg.m) begin
                    rd_addr   = p_reg[AW-1:0];
                    pend_next = 1'b1;
                    sub_next  = 1'b0;
                    p_next    = p_reg + CW'(1);
                end else if (!pend_reg) begin
                    p_next = CW'(1);
                    if (cnt_reg == cfg.target) begin
                        found_next = 1'b1;
                        st_next    = S_DONE;
                    end else if (cfg.r <= CW'(1)) begin
                        i_next  = i_reg + CW'(1);
                        st_next = S_NEXT;
                    end else begin
                        st_next = S_SLO;
                    end
                end
            end
            // slide: drop bit s-1
            S_SLO: begin
                rd_addr   = AW'(p_reg - CW'(1));
                pend_next = 1'b1;
                sub_next  = 1'b1;
                st_next   = S_SLI;
            end
            // slide: add bit s+m-1 mod r, then compare once that read has landed
            S_SLI: begin
                cnt_next  = eff_cnt;
                rd_addr   = (in_sum >= {1'b0, cfg.r}) ? AW'(in_sum - {1'b0, cfg.r})
                                                      : AW'(in_sum);
                pend_next = 1'b1;
                sub_next  = 1'b0;
                st_next   = S_SLI;
                if (pend_reg && !sub_reg) begin
                    // add just landed: compare and advance
                    pend_next = 1'b0;
                    if (eff_cnt == cfg.target) begin
                        found_next = 1'b1;
                        st_next    = S_DONE;
                    end else if (p_reg + CW'(1) >= cfg.r) begin
                        i_next  = i_reg + CW'(1);
                        st_next = S_NEXT;
                    end else begin
                        p_next  = p_reg + CW'(1);
                        st_next = S_SLO;
                    end
                end
            end
            S_DONE: begin
                st_next = S_IDLE;
            end
            default: st_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg    <= S_IDLE;
            pend_reg  <= 1'b0;
            found_reg <= 1'b0;
        end else begin
            st_reg    <= st_next;
            pend_reg  <= pend_next;
            found_reg <= found_next;
        end
        i_reg   <= i_next;
        p_reg   <= p_next;
        pos_reg <= pos_next;
        cnt_reg <= cnt_next;
        sub_reg <= sub_next;
    end

    assign stat.done  = (st_reg == S_DONE);
    assign stat.found = found_reg;
    assign stat.mult  = found_reg ? MultWidth'(i_reg) : '0;
endmodule

// ===== rtl/cyclic_cluster_orbit_checker_core.sv =====
// Top level of the cyclic cluster orbit checker: load, weigh, search, report.
//
// Coefficient bits load at one beat per cycle into the polynomial store. The
// beat that completes a polynomial of r bits ends the load and, if the weight
// and configuration pass, starts the orbit search; s_ready stays low until the
// result beat is taken. The weight is counted on the fly; if r was lowered
// during a load so that more than r bits were taken, the first r stored bits
// are weighed again first. For each multiplier i below r a subtractive gcd
// unit tests i against r; a coprime i then leads to permutation writes and to
// window sliding, all through one registered memory read port. With a weight
// mismatch or a bad configuration the result beat is offered from T_OUT,
// reached through T_EVAL without a search.
module cyclic_cluster_orbit_checker_core import ccoc_pkg::*; #(
    parameter int MaxLength = MaxLengthDef
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_we,
    input  logic [1:0]           cfg_index,
    input  logic [CfgWidth-1:0]  cfg_data,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic                 s_coef_bit,
    output logic                 m_valid,
    input  logic                 m_ready,
    output logic                 m_found,
    output logic [MultWidth-1:0] m_multiplier,
    output logic                 m_weight_ok,
    output logic                 m_bad_config
);
    localparam int AW = $clog2(MaxLength);
    localparam int CW = AW + 1;

    typedef enum logic [4:0] {
        T_LOAD = 5'b00001,
        T_WGT  = 5'b00010,
        T_EVAL = 5'b00100,
        T_SRCH = 5'b01000,
        T_OUT  = 5'b10000
    } top_st_t;

    top_st_t             st_reg, st_next;
    logic [CfgWidth-1:0] r_cfg_reg, w_cfg_reg, m_cfg_reg;
    logic                eps_reg;
    logic [CW-1:0]       load_reg, load_next;
    logic [CW-1:0]       wt_reg, wt_next;
    logic [CW-1:0]       scan_reg, scan_next;
    logic                pvld_reg, pvld_next;
    logic                poly_mem [MaxLength];
    logic                pbit;
    logic [AW-1:0]       prd_addr, rd_addr;
    logic [CW-1:0]       r_eff;
    logic                s_fire, full;
    logic                wok, bad, srch_start;
    logic                found_reg, wok_reg, bad_reg;
    logic [MultWidth-1:0] mult_reg;
    srch_cfg_t           scfg;
    srch_stat_t          sstat;

    // Configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            r_cfg_reg <= CfgWidth'(16384);
            w_cfg_reg <= '0;
            m_cfg_reg <= CfgWidth'(1);
            eps_reg   <= 1'b0;
        end else if (cfg_we) begin
            case (cfg_index)
                RegPolyLength:   r_cfg_reg <= cfg_data;
                RegTargetWeight: w_cfg_reg <= cfg_data;
                RegWindowLength: m_cfg_reg <= cfg_data;
                RegEpsilonMode:  eps_reg   <= cfg_data[0];
                default: ;
            endcase
        end
    end

    assign r_eff = (32'(r_cfg_reg) > MaxLength) ? CW'(MaxLength) : CW'(r_cfg_reg);
    assign s_ready = (st_reg == T_LOAD);
    assign s_fire  = s_valid && s_ready;

    // Polynomial store; the weigh pass owns the read port while it runs
    assign rd_addr = (st_reg == T_WGT) ? scan_reg[AW-1:0] : prd_addr;

    always_ff @(posedge aclk) begin
        if (s_fire && (load_reg < CW'(MaxLength))) begin
            poly_mem[load_reg[AW-1:0]] <= s_coef_bit;
        end
        pbit <= poly_mem[rd_addr];
    end

    // Weight over positions 0..r-1 against the target
    assign full = (load_next >= r_eff);
    assign wok  = (32'(wt_reg) == 32'(w_cfg_reg));
    assign bad  = (m_cfg_reg == '0) || (32'(m_cfg_reg) > 32'(r_eff)) || (r_eff < CW'(2));
    assign srch_start = (st_reg == T_EVAL) && wok && !bad && !(eps_reg && w_cfg_reg == '0);

    always_comb begin
        st_next   = st_reg;
        load_next = load_reg;
        wt_next   = wt_reg;
        scan_next = scan_reg;
        pvld_next = 1'b0;
        case (st_reg)
            T_LOAD: begin
                if (s_fire) begin
                    if (load_reg < CW'(MaxLength)) begin
                        load_next = load_reg + CW'(1);
                        wt_next   = wt_reg + CW'(s_coef_bit);
                    end
                    if (full) begin
                        if (load_next > r_eff) begin
                            // r was lowered mid-load: weigh the first r bits again
                            wt_next   = '0;
                            scan_next = '0;
                            st_next   = T_WGT;
                        end else begin
                            st_next = T_EVAL;
                        end
                    end
                end
            end
            // read positions 0..r-1, data lands the cycle after its read
            T_WGT: begin
                if (pvld_reg) wt_next = wt_reg + CW'(pbit);
                if (scan_reg < r_eff) begin
                    scan_next = scan_reg + CW'(1);
                    pvld_next = 1'b1;
                end else if (!pvld_reg) begin
                    st_next = T_EVAL;
                end
            end
            T_EVAL: st_next = srch_start ? T_SRCH : T_OUT;
            T_SRCH: if (sstat.done) st_next = T_OUT;
            T_OUT: begin
                if (m_ready) begin
                    st_next   = T_LOAD;
                    load_next = '0;
                    wt_next   = '0;
                end
            end
            default: st_next = T_LOAD;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg   <= T_LOAD;
            load_reg <= '0;
            wt_reg   <= '0;
            scan_reg <= '0;
            pvld_reg <= 1'b0;
        end else begin
            st_reg   <= st_next;
            load_reg <= load_next;
            wt_reg   <= wt_next;
            scan_reg <= scan_next;
            pvld_reg <= pvld_next;
        end
    end

    // Result register
    always_ff @(posedge aclk) begin
        if (st_reg == T_EVAL) begin
            wok_reg   <= wok;
            bad_reg   <= bad;
            found_reg <= 1'b0;
            mult_reg  <= '0;
        end else if (st_reg == T_SRCH && sstat.done) begin
            found_reg <= sstat.found;
            mult_reg  <= sstat.mult;
        end
    end

    assign scfg.r      = CfgWidth'(r_eff);
    assign scfg.m      = m_cfg_reg;
    assign scfg.target = eps_reg ? w_cfg_reg - CfgWidth'(1) : w_cfg_reg;

    ccoc_search #(.MaxLength(MaxLength)) u_search (
        .aclk(aclk), .aresetn(aresetn), .start(srch_start), .cfg(scfg),
        .prd_addr(prd_addr), .pbit(pbit), .stat(sstat)
    );

    assign m_valid      = (st_reg == T_OUT);
    assign m_found      = found_reg;
    assign m_multiplier = mult_reg;
    assign m_weight_ok  = wok_reg;
    assign m_bad_config = bad_reg;

    // No input beats while a result waits
    a_no_in_during_out: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> !s_ready) else $error("input accepted while result pending");
    // A found result carries a nonzero multiplier
    a_found_mult: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_found) |-> (m_multiplier != '0)) else $error("found with zero multiplier");
    // Bad configuration never reports a match
    a_bad_nofound: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_bad_config) |-> !m_found) else $error("match under bad config");
endmodule
